FILE: hdl/vlan_port_filter_top_defines.svh
// ----------------------------------------------------------------------------
// vlan_port_filter_top_defines.svh
// Assertion macros shared by the VLAN port filter checker.
// ----------------------------------------------------------------------------
`ifndef VLAN_PORT_FILTER_TOP_DEFINES_SVH
`define VLAN_PORT_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/vpf_pkg.sv
// ----------------------------------------------------------------------------
// vpf_pkg
// Sizes, codes and table entry type of the VLAN port filter.
// ----------------------------------------------------------------------------
package vpf_pkg;

   localparam int NUM_PORTS = 32;
   localparam int NUM_VLANS = 4096;
   localparam int PORT_AW   = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int VLAN_AW   = (NUM_VLANS > 1) ? $clog2(NUM_VLANS) : 1;

   // Field widths of the request and response beats
   localparam int TYPE_W = 3;
   localparam int PORT_W = 5;
   localparam int VID_W  = 12;
   localparam int KIND_W = 2;

   localparam logic [TYPE_W-1:0] REQ_PORT_WR   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_MEMBER_WR = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INGRESS   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_EGRESS    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_FORWARD   = 3'd4;

   localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRUNK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HYBRID = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [VID_W-1:0]  native;
      logic              keep_tag;
   } port_entry_type;

endpackage

FILE: hdl/vlan_port_filter_top.sv
// ----------------------------------------------------------------------------
// vlan_port_filter_top
// Per-port 802.1Q VLAN filter and tag handler around a port table and a
// VLAN membership RAM.
// ----------------------------------------------------------------------------
// Usage:
// - Request channel (req_*): one beat per item: port write, membership
//   write, ingress check, egress check or forward check. Every beat gives
//   exactly one response beat on rsp_*, in order.
// - Order: the request fields and the table reads are registered, then
//   the result is loaded into the response register; an untagged
//   ingress on a trunk or hybrid port first takes a second read, because
//   the native VLAN from the port table must address the membership RAM.
// - One item at a time: req_stall stays high from the request until its
//   result is loaded into the response register, so no new request is
//   taken while an item runs its port table and membership RAM reads.
// - Reset: port valid bits clear at once; then the membership RAM is
//   swept to zero, one VLAN per cycle, over all NUM_VLANS entries (4096)
//   while req_stall stays high.
// - Stall: the response register holds while rsp_stall is high. A new
//   request is still taken in that time; its result waits in the lookup
//   stage until the response register frees up.
// ----------------------------------------------------------------------------
module vlan_port_filter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [vpf_pkg::TYPE_W-1:0]  req_type,
   input  logic [vpf_pkg::PORT_W-1:0]  req_port,
   input  logic [vpf_pkg::PORT_W-1:0]  req_other_port,
   input  logic                        req_tagged_req,
   input  logic [vpf_pkg::VID_W-1:0]   req_vlan_id,
   input  logic [vpf_pkg::KIND_W-1:0]  req_set_kind,
   input  logic [vpf_pkg::VID_W-1:0]   req_set_native_vlan,
   input  logic                        req_set_tag_native,
   input  logic                        req_member_bit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_verdict,
   output logic                        rsp_out_tagged,
   output logic [vpf_pkg::VID_W-1:0]   rsp_out_vlan_id,
   output logic                        rsp_tag_pushed,
   output logic                        rsp_tag_popped
);

   import vpf_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_NATIVE
   } state_type;

   localparam int ENTRY_W = $bits(port_entry_type);

   state_type              state_ff, state_in;
   logic [VLAN_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [NUM_PORTS-1:0]   valid_ff, valid_in;

   // Item held while its lookups run
   logic [TYPE_W-1:0]      type_ff, type_in;
   logic [PORT_W-1:0]      port_ff, port_in;
   logic [PORT_W-1:0]      other_ff, other_in;
   logic                   tagged_ff, tagged_in;
   logic [VID_W-1:0]       vid_ff, vid_in;
   logic                   mb_ff, mb_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_verdict_ff, rsp_verdict_in;
   logic                   rsp_tagged_ff, rsp_tagged_in;
   logic [VID_W-1:0]       rsp_vid_ff, rsp_vid_in;
   logic                   rsp_pushed_ff, rsp_pushed_in;
   logic                   rsp_popped_ff, rsp_popped_in;

   logic                   accept;
   logic                   out_free;
   logic                   go_native;
   logic                   done;
   logic                   load;

   logic                   in_p_ok;
   logic [PORT_AW-1:0]     in_p_idx;
   logic                   p_ok, q_ok, vid_ok, nat_ok;
   logic [PORT_AW-1:0]     p_idx, q_idx;
   logic                   cfg_p, cfg_q;
   logic                   p_trunk;
   logic                   match_p, match_q;

   port_entry_type         wr_entry;
   logic [ENTRY_W-1:0]     pa_raw, pb_raw;
   port_entry_type         pa, pb;
   logic                   port_wr_en;

   logic                   mem_wr_en;
   logic [VLAN_AW-1:0]     mem_wr_addr;
   logic [NUM_PORTS-1:0]   mem_wr_data;
   logic                   mem_rd_en;
   logic [VLAN_AW-1:0]     mem_rd_addr;
   logic [NUM_PORTS-1:0]   mem_word;

   logic                   res_verdict, res_tagged, res_pushed, res_popped;
   logic [VID_W-1:0]       res_vid;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Port table: two copies so that both ports of a forward check read in
   // the same cycle. Valid bits live in flops and gate the stale contents.
   // ---------------------------------------------------------------------
   assign in_p_idx   = PORT_AW'(req_port);
   assign in_p_ok    = (32'(req_port) < 32'(NUM_PORTS));
   assign port_wr_en = accept && (req_type == REQ_PORT_WR) && in_p_ok;

   always_comb begin
      wr_entry          = '0;
      wr_entry.kind     = req_set_kind;
      wr_entry.native   = req_set_native_vlan;
      wr_entry.keep_tag = req_set_tag_native;
   end

   vpf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_PORTS)
   ) u_port_ram_a (
      .clock   (clock),
      .wr_en   (port_wr_en),
      .wr_addr (in_p_idx),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (PORT_AW'(req_port)),
      .rd_data (pa_raw)
   );

   vpf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_PORTS)
   ) u_port_ram_b (
      .clock   (clock),
      .wr_en   (port_wr_en),
      .wr_addr (in_p_idx),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (PORT_AW'(req_other_port)),
      .rd_data (pb_raw)
   );

   assign pa = port_entry_type'(pa_raw);
   assign pb = port_entry_type'(pb_raw);

   // ---------------------------------------------------------------------
   // Decode of the held item against the lookup results
   // ---------------------------------------------------------------------
   assign p_idx  = PORT_AW'(port_ff);
   assign q_idx  = PORT_AW'(other_ff);
   assign p_ok   = (32'(port_ff) < 32'(NUM_PORTS));
   assign q_ok   = (32'(other_ff) < 32'(NUM_PORTS));
   assign vid_ok = (32'(vid_ff) < 32'(NUM_VLANS));
   assign nat_ok = (32'(pa.native) < 32'(NUM_VLANS));
   assign cfg_p  = p_ok && valid_ff[p_idx];
   assign cfg_q  = q_ok && valid_ff[q_idx];

   assign p_trunk = (pa.kind == KIND_TRUNK) || (pa.kind == KIND_HYBRID);

   // Access ports match their native VLAN only; every other kind uses
   // the membership bitmap.
   assign match_p = (pa.kind == KIND_ACCESS) ? (vid_ff == pa.native)
                                              : (vid_ok && mem_word[p_idx]);
   assign match_q = (pb.kind == KIND_ACCESS) ? (vid_ff == pb.native)
                                              : (vid_ok && mem_word[q_idx]);

   // Untagged ingress on a trunk or hybrid port needs a second read at the native VLAN
   assign go_native = (state_ff == ST_LOOK) && (type_ff == REQ_INGRESS) &&
                      cfg_p && !tagged_ff && p_trunk;
   assign done      = ((state_ff == ST_LOOK) && !go_native) ||
                      (state_ff == ST_NATIVE);
   assign load      = done && out_free;

   always_comb begin
      res_verdict = 1'b0;
      res_tagged  = 1'b0;
      res_vid     = '0;
      res_pushed  = 1'b0;
      res_popped  = 1'b0;
      if (state_ff == ST_NATIVE) begin
         // Native VLAN membership now on the read port
         if (nat_ok && mem_word[p_idx]) begin
            res_vid = pa.native;
         end else begin
            res_verdict = 1'b1;
         end
      end else begin
         case (type_ff)
            REQ_INGRESS: begin
               res_tagged = tagged_ff;
               res_vid    = tagged_ff ? vid_ff : '0;
               if (!cfg_p) begin
                  res_verdict = 1'b1;
               end else if (pa.kind == KIND_ACCESS) begin
                  if (tagged_ff) begin
                     res_verdict = (vid_ff != pa.native);
                  end else begin
                     res_pushed = 1'b1;
                     res_tagged = 1'b1;
                     res_vid    = pa.native;
                  end
               end else if (p_trunk) begin
                  res_verdict = !(vid_ok && mem_word[p_idx]);
               end else begin
                  res_verdict = 1'b1;
               end
            end
            REQ_EGRESS: begin
               res_tagged = tagged_ff;
               res_vid    = tagged_ff ? vid_ff : '0;
               if (tagged_ff && cfg_p) begin
                  if (((pa.kind == KIND_ACCESS) && (vid_ff == pa.native)) ||
                      (p_trunk && (vid_ff == pa.native) && !pa.keep_tag)) begin
                     res_popped = 1'b1;
                     res_tagged = 1'b0;
                  end
               end
            end
            REQ_FORWARD: begin
               res_vid     = vid_ff;
               res_verdict = !(cfg_p && cfg_q && match_p && match_q);
            end
            default: begin
               // writes and unused codes answer with zeros
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Membership RAM: one word per VLAN, one bit per port. Written by the
   // reset sweep and by read-modify-write of membership writes.
   // ---------------------------------------------------------------------
   always_comb begin
      mem_wr_data        = mem_word;
      mem_wr_data[p_idx] = mb_ff;
      if (state_ff == ST_CLEAR) begin
         mem_wr_data = '0;
      end
   end

   assign mem_wr_en   = (state_ff == ST_CLEAR) ||
                        ((state_ff == ST_LOOK) && (type_ff == REQ_MEMBER_WR) &&
                         p_ok && vid_ok && load);
   assign mem_wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : VLAN_AW'(vid_ff);
   assign mem_rd_en   = accept || go_native;
   assign mem_rd_addr = (state_ff == ST_LOOK) ? VLAN_AW'(pa.native)
                                              : VLAN_AW'(req_vlan_id);

   vpf_ram #(
      .WIDTH (NUM_PORTS),
      .DEPTH (NUM_VLANS)
   ) u_member_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_word)
   );

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      valid_in   = valid_ff;
      type_in    = type_ff;
      port_in    = port_ff;
      other_in   = other_ff;
      tagged_in  = tagged_ff;
      vid_in     = vid_ff;
      mb_in      = mb_ff;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the membership RAM, one VLAN per cycle
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == VLAN_AW'(NUM_VLANS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               type_in   = req_type;
               port_in   = req_port;
               other_in  = req_other_port;
               tagged_in = req_tagged_req;
               vid_in    = req_vlan_id;
               mb_in     = req_member_bit;
               state_in  = ST_LOOK;
               if (port_wr_en) begin
                  valid_in[in_p_idx] = 1'b1;
               end
            end
         end
         ST_LOOK: begin
            if (go_native) begin
               state_in = ST_NATIVE;
            end else if (load) begin
               state_in = ST_IDLE;
            end
         end
         ST_NATIVE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: load a finished result, hold while stalled
   assign rsp_valid_in   = load || (rsp_valid_ff && rsp_stall);
   assign rsp_verdict_in = load ? res_verdict : rsp_verdict_ff;
   assign rsp_tagged_in  = load ? res_tagged  : rsp_tagged_ff;
   assign rsp_vid_in     = load ? res_vid     : rsp_vid_ff;
   assign rsp_pushed_in  = load ? res_pushed  : rsp_pushed_ff;
   assign rsp_popped_in  = load ? res_popped  : rsp_popped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff        <= type_in;
      port_ff        <= port_in;
      other_ff       <= other_in;
      tagged_ff      <= tagged_in;
      vid_ff         <= vid_in;
      mb_ff          <= mb_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_tagged_ff  <= rsp_tagged_in;
      rsp_vid_ff     <= rsp_vid_in;
      rsp_pushed_ff  <= rsp_pushed_in;
      rsp_popped_ff  <= rsp_popped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_out_tagged  = rsp_tagged_ff;
   assign rsp_out_vlan_id = rsp_vid_ff;
   assign rsp_tag_pushed  = rsp_pushed_ff;
   assign rsp_tag_popped  = rsp_popped_ff;

endmodule

FILE: hdl/vpf_ram.sv
// ----------------------------------------------------------------------------
// vpf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/vpf_checker.sv
// ----------------------------------------------------------------------------
// vpf_checker
// Port-level checks of the VLAN port filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "vlan_port_filter_top_defines.svh"

module vpf_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_verdict,
   input  logic                        rsp_out_tagged,
   input  logic [vpf_pkg::VID_W-1:0]   rsp_out_vlan_id,
   input  logic                        rsp_tag_pushed,
   input  logic                        rsp_tag_popped
);

   // A stalled response beat holds its value
   `VPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_vlan_id) && $stable(rsp_verdict), "stalled response beat changed")

   // The block works on one item at a time: busy right after taking a beat
   `VPF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request taken while previous item in flight")

   // A pushed tag means an accepted, tagged packet with nothing popped
   `VPF_ASSERT_NOW(a_push_tagged, clock, reset, rsp_valid && rsp_tag_pushed, rsp_out_tagged && !rsp_verdict && !rsp_tag_popped, "tag push with inconsistent fields")

   // A popped tag leaves the packet untagged and forwarded
   `VPF_ASSERT_NOW(a_pop_untagged, clock, reset, rsp_valid && rsp_tag_popped, !rsp_out_tagged && !rsp_verdict, "tag pop with inconsistent fields")

endmodule

bind vlan_port_filter_top vpf_checker u_vpf_checker (.*);

FILE: tb/sv/tb_vlan_port_filter_top.sv
// ----------------------------------------------------------------------------
// tb_vlan_port_filter_top
// Self-checking bench for the per-port VLAN filter. It drives port writes,
// membership writes, ingress, egress and forward checks, and predicts every
// response beat from a private copy of the port table and membership map.
// Each response beat is compared field by field, in order, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_vlan_port_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vpf_pkg::*;

   // Run shape
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1800;
   localparam int IDLE_PCT     = 34;
   localparam int CALM_FIRST   = 900;   // random items with no idling on
   localparam int CALM_LAST    = 1200;  // either side, first index and end index (exclusive)
   localparam int HOLD_AFTER   = 500;   // request beats taken before hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   // Reset, the membership sweep over all 4096 VLANs, the hold-off and ~1800
   // items plus random stalls fit well inside this.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int MAX_REPORTS  = 10;

   // Codes the package leaves unnamed
   localparam logic [TYPE_W-1:0] REQ_TYPE_TOP  = 3'd7;
   localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
   localparam logic [VID_W-1:0]  VID_TOP       = '1;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [PORT_W-1:0] port;
      logic [PORT_W-1:0] other_port;
      logic              tagged_req;
      logic [VID_W-1:0]  vlan_id;
      logic [KIND_W-1:0] set_kind;
      logic [VID_W-1:0]  set_native_vlan;
      logic              set_tag_native;
      logic              member_bit;
   } filter_req_type;

   typedef struct packed {
      logic             verdict;
      logic             out_tagged;
      logic [VID_W-1:0] out_vlan_id;
      logic             tag_pushed;
      logic             tag_popped;
   } filter_rsp_type;

   // -------------------------------------------------------------------------
   // Decision board: mirrors the port table and membership map, predicts the
   // decision for each accepted request and checks response beats in order.
   // -------------------------------------------------------------------------
   class vlan_decision_board;
      typedef struct {
         filter_req_type req;
         filter_rsp_type rsp;
      } due_entry_type;

      bit                 port_on      [NUM_PORTS];
      bit [KIND_W-1:0]    port_mode    [NUM_PORTS];
      bit [VID_W-1:0]     port_pvid    [NUM_PORTS];
      bit                 port_keep_tag[NUM_PORTS];
      bit [NUM_PORTS-1:0] vlan_ports   [NUM_VLANS];
      due_entry_type      decisions_due[$];
      int                 failures;
      int                 type_count[8];
      int                 drops;
      int                 pushes;
      int                 pops;

      function bit port_matches(int p, bit [VID_W-1:0] vid);
         if (port_mode[p] == KIND_ACCESS) return vid == port_pvid[p];
         return vlan_ports[vid][p];
      endfunction

      function filter_rsp_type decide(filter_req_type r);
         filter_rsp_type d;
         int             p;
         int             q;
         bit [VID_W-1:0] pvid;
         bit             trunk_like;
         d = '0;
         p = int'(r.port);
         q = int'(r.other_port);
         pvid = r.tagged_req ? r.vlan_id : '0;
         trunk_like = port_mode[p] == KIND_TRUNK || port_mode[p] == KIND_HYBRID;
         case (r.req_type)
            REQ_PORT_WR: begin
               port_on[p]       = 1'b1;
               port_mode[p]     = r.set_kind;
               port_pvid[p]     = r.set_native_vlan;
               port_keep_tag[p] = r.set_tag_native;
            end
            REQ_MEMBER_WR: vlan_ports[r.vlan_id][p] = r.member_bit;
            REQ_INGRESS: begin
               d.out_tagged  = r.tagged_req;
               d.out_vlan_id = pvid;
               if (!port_on[p]) begin
                  d.verdict = 1'b1;
               end else if (port_mode[p] == KIND_ACCESS) begin
                  if (!r.tagged_req) begin
                     d.tag_pushed  = 1'b1;
                     d.out_tagged  = 1'b1;
                     d.out_vlan_id = port_pvid[p];
                  end else if (pvid != port_pvid[p]) begin
                     d.verdict = 1'b1;
                  end
               end else if (!trunk_like) begin
                  d.verdict = 1'b1;
               end else if (r.tagged_req) begin
                  d.verdict = !vlan_ports[pvid][p];
               end else if (vlan_ports[port_pvid[p]][p]) begin
                  d.out_vlan_id = port_pvid[p];
               end else begin
                  d.verdict = 1'b1;
               end
            end
            REQ_EGRESS: begin
               d.out_tagged  = r.tagged_req;
               d.out_vlan_id = pvid;
               if (r.tagged_req && port_on[p] && r.vlan_id == port_pvid[p] &&
                   (port_mode[p] == KIND_ACCESS || (trunk_like && !port_keep_tag[p]))) begin
                  d.tag_popped = 1'b1;
                  d.out_tagged = 1'b0;
               end
            end
            REQ_FORWARD: begin
               d.out_vlan_id = r.vlan_id;
               d.verdict = !(port_on[p] && port_on[q] &&
                             port_matches(p, r.vlan_id) && port_matches(q, r.vlan_id));
            end
            default: ;
         endcase
         return d;
      endfunction

      function void take_request(filter_req_type r);
         due_entry_type e;
         e.req = r;
         e.rsp = decide(r);
         type_count[int'(r.req_type)]++;
         drops  += int'(e.rsp.verdict);
         pushes += int'(e.rsp.tag_pushed);
         pops   += int'(e.rsp.tag_popped);
         decisions_due.push_back(e);
      endfunction

      function void check_decision(filter_rsp_type got);
         due_entry_type e;
         if (decisions_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR: response beat with no request pending: %p", got);
            return;
         end
         e = decisions_due.pop_front();
         if (got.verdict !== e.rsp.verdict || got.out_tagged !== e.rsp.out_tagged ||
             got.out_vlan_id !== e.rsp.out_vlan_id || got.tag_pushed !== e.rsp.tag_pushed ||
             got.tag_popped !== e.rsp.tag_popped) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("ERROR: type %0d port %0d/%0d tagged %0d vid %0d",
                        e.req.req_type, e.req.port, e.req.other_port, e.req.tagged_req,
                        e.req.vlan_id);
               $display("   exp drop=%0d tag=%0d vid=%0d push=%0d pop=%0d",
                        e.rsp.verdict, e.rsp.out_tagged, e.rsp.out_vlan_id,
                        e.rsp.tag_pushed, e.rsp.tag_popped);
               $display("   got drop=%0d tag=%0d vid=%0d push=%0d pop=%0d",
                        got.verdict, got.out_tagged, got.out_vlan_id,
                        got.tag_pushed, got.tag_popped);
            end
         end
      endfunction

      function int pending();
         return decisions_due.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic           clock      = 1'b0;
   logic           reset      = 1'b1;
   logic           req_valid  = 1'b0;
   logic           req_stall;
   filter_req_type req_beat   = '0;
   logic           rsp_valid;
   logic           rsp_stall  = 1'b0;
   filter_rsp_type rsp_seen;

   vlan_decision_board board;
   bit [VID_W-1:0]     vlan_pool[8];
   bit                 calm_phase = 1'b0;
   int                 beats_in   = 0;
   int                 cycle_count = 0;

   always #1 clock = ~clock;

   vlan_port_filter_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_beat.req_type),
      .req_port            (req_beat.port),
      .req_other_port      (req_beat.other_port),
      .req_tagged_req      (req_beat.tagged_req),
      .req_vlan_id         (req_beat.vlan_id),
      .req_set_kind        (req_beat.set_kind),
      .req_set_native_vlan (req_beat.set_native_vlan),
      .req_set_tag_native  (req_beat.set_tag_native),
      .req_member_bit      (req_beat.member_bit),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_seen.verdict),
      .rsp_out_tagged      (rsp_seen.out_tagged),
      .rsp_out_vlan_id     (rsp_seen.out_vlan_id),
      .rsp_tag_pushed      (rsp_seen.tag_pushed),
      .rsp_tag_popped      (rsp_seen.tag_popped)
   );

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic filter_req_type make_req(logic [TYPE_W-1:0] t, int p, int q, int tg,
                                               int vid, logic [KIND_W-1:0] k,
                                               int nat, int tn, int mb);
      filter_req_type r;
      r.req_type        = t;
      r.port            = PORT_W'(p);
      r.other_port      = PORT_W'(q);
      r.tagged_req      = 1'(tg);
      r.vlan_id         = VID_W'(vid);
      r.set_kind        = k;
      r.set_native_vlan = VID_W'(nat);
      r.set_tag_native  = 1'(tn);
      r.member_bit      = 1'(mb);
      return r;
   endfunction

   // Favor a handful of ports so that writes and checks meet each other.
   function automatic logic [PORT_W-1:0] pick_hot_port();
      int h;
      h = $urandom_range(7);
      return PORT_W'(h < 4 ? h : h + NUM_PORTS - 8);
   endfunction

   // Randomize every field, then bias the ones the chosen type reads toward
   // the hot ports and the VLAN pool, so that ingress and forward checks
   // often find configured ports and set membership bits.
   function automatic filter_req_type roll_request();
      filter_req_type r;
      int             dice;
      r.req_type        = TYPE_W'($urandom);
      r.port            = PORT_W'($urandom);
      r.other_port      = PORT_W'($urandom);
      r.tagged_req      = 1'($urandom);
      r.vlan_id         = VID_W'($urandom);
      r.set_native_vlan = VID_W'($urandom);
      r.set_tag_native  = 1'($urandom);
      dice = $urandom_range(99);
      if (dice < 8) r.req_type = REQ_PORT_WR;
      else if (dice < 22) r.req_type = REQ_MEMBER_WR;
      else if (dice < 52) r.req_type = REQ_INGRESS;
      else if (dice < 70) r.req_type = REQ_EGRESS;
      else if (dice < 96) r.req_type = REQ_FORWARD;
      else r.req_type = TYPE_W'($urandom_range(int'(REQ_FORWARD) + 1, int'(REQ_TYPE_TOP)));
      if ($urandom_range(99) < 75) r.port = pick_hot_port();
      if ($urandom_range(99) < 75) r.other_port = pick_hot_port();
      if ($urandom_range(99) < 80) r.vlan_id = vlan_pool[$urandom_range(7)];
      if ($urandom_range(99) < 80) r.set_native_vlan = vlan_pool[$urandom_range(7)];
      r.set_kind = ($urandom_range(99) < 5) ? KIND_RESERVED
                                             : KIND_W'($urandom_range(int'(KIND_HYBRID)));
      r.member_bit = $urandom_range(99) < 70;
      return r;
   endfunction

   // Offer one request beat. Call at a falling edge; return at the falling
   // edge after the beat is taken. Idle first at random unless calm.
   task automatic offer_beat(input filter_req_type r);
      while (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_beat  = r;
      req_valid = 1'b1;
      // Hold the payload until a rising edge sees stall low.
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Check the response
   // first so a stray beat never pairs with the request taken this edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_decision(rsp_seen);
         if (req_valid && !req_stall) begin
            board.take_request(req_beat);
            beats_in++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response side: stall at random, never in the calm stretch, and once
   // hold off for a long stretch so the block fills and stalls its input.
   // -------------------------------------------------------------------------
   initial begin
      bit held_off;
      held_off = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && beats_in >= HOLD_AFTER) begin
            held_off  = 1'b1;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall = !calm_phase && $urandom_range(99) < IDLE_PCT;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if it drags on far past any correct run.
   // -------------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d responses still due", cycle_count,
               board.pending());
      $display("vlan_port_filter_top verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int idx;
      board = new();
      vlan_pool[0] = '0;
      vlan_pool[1] = VID_TOP;
      for (idx = 2; idx < 8; idx++) vlan_pool[idx] = VID_W'($urandom);

      // Hold reset, then release it on a falling edge. The membership sweep
      // that follows shows up as req_stall, which offer_beat waits out.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: unconfigured ports first, then one port of each kind.
      offer_beat(make_req(REQ_INGRESS, 0, 0, 1, int'(VID_TOP), KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_EGRESS, 0, 0, 1, 10, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_FORWARD, 0, 31, 0, 0, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_PORT_WR, 0, 0, 0, 0, KIND_ACCESS, int'(VID_TOP), 1, 0));
      offer_beat(make_req(REQ_PORT_WR, 31, 0, 0, 0, KIND_TRUNK, 0, 0, 0));
      offer_beat(make_req(REQ_PORT_WR, 7, 0, 0, 0, KIND_HYBRID, 100, 1, 0));
      offer_beat(make_req(REQ_PORT_WR, 12, 0, 0, 0, KIND_RESERVED, 5, 0, 0));
      offer_beat(make_req(REQ_MEMBER_WR, 31, 0, 0, 0, KIND_ACCESS, 0, 0, 1));
      offer_beat(make_req(REQ_MEMBER_WR, 31, 0, 0, int'(VID_TOP), KIND_ACCESS, 0, 0, 1));
      offer_beat(make_req(REQ_MEMBER_WR, 7, 0, 0, 100, KIND_ACCESS, 0, 0, 1));
      // Access: push native on untagged, pass native, drop foreign tag.
      offer_beat(make_req(REQ_INGRESS, 0, 0, 0, 1234, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_INGRESS, 0, 0, 1, int'(VID_TOP), KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_INGRESS, 0, 0, 1, 5, KIND_ACCESS, 0, 0, 0));
      // Trunk and hybrid untagged take the second membership read; then tagged hybrid and reserved kind.
      offer_beat(make_req(REQ_INGRESS, 31, 0, 0, 77, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_INGRESS, 7, 0, 0, 0, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_INGRESS, 7, 0, 1, 300, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_INGRESS, 12, 0, 1, 5, KIND_ACCESS, 0, 0, 0));
      // Egress: pop on access native, pop on trunk without tag-native,
      // keep with tag-native, leave reserved kind untouched.
      offer_beat(make_req(REQ_EGRESS, 0, 0, 1, int'(VID_TOP), KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_EGRESS, 31, 0, 1, 0, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_EGRESS, 7, 0, 1, 100, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_EGRESS, 12, 0, 1, 5, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_FORWARD, 0, 31, 0, int'(VID_TOP), KIND_ACCESS, 0, 0, 0));
      // Clear the trunk's native membership: untagged ingress must drop.
      offer_beat(make_req(REQ_MEMBER_WR, 31, 0, 0, 0, KIND_ACCESS, 0, 0, 0));
      offer_beat(make_req(REQ_INGRESS, 31, 0, 0, 0, KIND_ACCESS, 0, 0, 0));
      // Unused type with every field at its top value changes nothing.
      offer_beat(make_req(REQ_TYPE_TOP, 31, 31, 1, int'(VID_TOP), KIND_RESERVED,
                          int'(VID_TOP), 1, 1));

      // Random part, with a stretch of back-to-back traffic in the middle.
      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         calm_phase = idx >= CALM_FIRST && idx < CALM_LAST;
         offer_beat(roll_request());
      end
      calm_phase = 1'b0;
      req_valid  = 1'b0;

      // Drain: wait for every predicted beat, then watch for strays.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d beats: %0d port wr, %0d member wr, %0d ingress,",
               beats_in, board.type_count[REQ_PORT_WR], board.type_count[REQ_MEMBER_WR],
               board.type_count[REQ_INGRESS]);
      $display("   %0d egress, %0d forward, %0d unused",
               board.type_count[REQ_EGRESS], board.type_count[REQ_FORWARD],
               beats_in - board.type_count[REQ_PORT_WR] -
               board.type_count[REQ_MEMBER_WR] - board.type_count[REQ_INGRESS] -
               board.type_count[REQ_EGRESS] - board.type_count[REQ_FORWARD]);
      $display("Decisions: %0d drops, %0d tag pushes, %0d tag pops; %0d mismatches",
               board.drops, board.pushes, board.pops, board.failures);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("vlan_port_filter_top verification clean");
      end else begin
         $display("vlan_port_filter_top verification failed");
      end
      $finish;
   end

endmodule
